[sv/cgfr_pkg.sv]
// Shared types and constants for the character glyph frame buffer renderer.
// Holds the request codes, glyph geometry and the built-in 5x7 font lookup.
// No dependencies.
`default_nettype none

package cgfr_pkg;

    // Glyph geometry and page layout
    localparam int GLYPH_COLS = 5;
    localparam int GLYPH_ROWS = 7;
    localparam int PAGE_BITS  = 8;

    // Draw sequencer: two page bytes per glyph column
    localparam int STEPS  = 2 * GLYPH_COLS;
    localparam int STEP_W = $clog2(STEPS);

    // Request codes
    localparam logic [1:0] REQ_DRAW  = 2'd0;
    localparam logic [1:0] REQ_CLEAR = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    // One glyph: column c at index c, bit r of a column is row r
    typedef logic [GLYPH_COLS-1:0][GLYPH_ROWS-1:0] glyph_t;

    function automatic glyph_t glyph_pack(
        input logic [GLYPH_ROWS-1:0] c0,
        input logic [GLYPH_ROWS-1:0] c1,
        input logic [GLYPH_ROWS-1:0] c2,
        input logic [GLYPH_ROWS-1:0] c3,
        input logic [GLYPH_ROWS-1:0] c4
    );
        glyph_t g;
        g[0] = c0;
        g[1] = c1;
        g[2] = c2;
        g[3] = c3;
        g[4] = c4;
        return g;
    endfunction

    // Font lookup; any code without a glyph draws blank
    function automatic glyph_t glyph_lookup(input logic [7:0] code);
        glyph_t g;
        unique case (code)
            8'h30:   g = glyph_pack(7'h3E, 7'h51, 7'h49, 7'h45, 7'h3E); // 0
            8'h31:   g = glyph_pack(7'h00, 7'h42, 7'h7F, 7'h40, 7'h00); // 1
            8'h32:   g = glyph_pack(7'h42, 7'h61, 7'h51, 7'h49, 7'h46); // 2
            8'h33:   g = glyph_pack(7'h21, 7'h41, 7'h45, 7'h4B, 7'h31); // 3
            8'h34:   g = glyph_pack(7'h18, 7'h14, 7'h12, 7'h7F, 7'h10); // 4
            8'h35:   g = glyph_pack(7'h27, 7'h45, 7'h45, 7'h45, 7'h39); // 5
            8'h36:   g = glyph_pack(7'h3C, 7'h4A, 7'h49, 7'h49, 7'h30); // 6
            8'h37:   g = glyph_pack(7'h01, 7'h71, 7'h09, 7'h05, 7'h03); // 7
            8'h38:   g = glyph_pack(7'h36, 7'h49, 7'h49, 7'h49, 7'h36); // 8
            8'h39:   g = glyph_pack(7'h06, 7'h49, 7'h49, 7'h29, 7'h1E); // 9
            8'h41:   g = glyph_pack(7'h7E, 7'h11, 7'h11, 7'h11, 7'h7E); // A
            8'h46:   g = glyph_pack(7'h7F, 7'h09, 7'h09, 7'h09, 7'h01); // F
            8'h47:   g = glyph_pack(7'h3E, 7'h41, 7'h49, 7'h49, 7'h7A); // G
            8'h48:   g = glyph_pack(7'h7F, 7'h08, 7'h08, 7'h08, 7'h7F); // H
            8'h4B:   g = glyph_pack(7'h7F, 7'h08, 7'h14, 7'h22, 7'h41); // K
            8'h4C:   g = glyph_pack(7'h7F, 7'h40, 7'h40, 7'h40, 7'h40); // L
            8'h4D:   g = glyph_pack(7'h7F, 7'h02, 7'h0C, 7'h02, 7'h7F); // M
            8'h4F:   g = glyph_pack(7'h3E, 7'h41, 7'h41, 7'h41, 7'h3E); // O
            8'h58:   g = glyph_pack(7'h63, 7'h14, 7'h08, 7'h14, 7'h63); // X
            8'h59:   g = glyph_pack(7'h07, 7'h08, 7'h70, 7'h08, 7'h07); // Y
            8'h5A:   g = glyph_pack(7'h61, 7'h51, 7'h49, 7'h45, 7'h43); // Z
            8'h3A:   g = glyph_pack(7'h00, 7'h36, 7'h36, 7'h00, 7'h00); // colon
            8'h2D:   g = glyph_pack(7'h08, 7'h08, 7'h08, 7'h08, 7'h08); // dash
            8'h2E:   g = glyph_pack(7'h00, 7'h60, 7'h60, 7'h00, 7'h00); // dot
            8'h25:   g = glyph_pack(7'h62, 7'h64, 7'h08, 7'h13, 7'h23); // percent
            8'h20:   g = '0;                                            // space
            default: g = '0;
        endcase
        return g;
    endfunction

endpackage

`default_nettype wire

[sv/char_glyph_framebuffer_renderer.sv]
// Top level of the character glyph frame buffer renderer.
// Holds the page-layout frame store, the draw sequencer and the read path.
// Depends on cgfr_pkg.
//
// Monochrome SCREEN_WIDTH x SCREEN_HEIGHT frame store in page layout: byte
// x + (y/8)*SCREEN_WIDTH holds eight vertical pixels, bit y%8 is the pixel.
// The store is one synchronous RAM with one write and one registered read port.
// One item is in work at a time. A draw is accepted and then runs ten
// sequencer steps, one page byte per step, read-modify-written through a
// two-stage pipeline (read in one cycle, OR and write back in the next). A read
// waits while the output register is stalled. A clear sweeps the RAM one byte
// a cycle. After reset the same sweep runs before the first item is taken.
// Off-screen glyph pixels are dropped; a read past the last byte returns zero.
`default_nettype none

module char_glyph_framebuffer_renderer
    import cgfr_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 128,
    parameter int SCREEN_HEIGHT = 64
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [1:0] req_type,
    input  wire logic [7:0] pos_x,
    input  wire logic [6:0] pos_y,
    input  wire logic [7:0] char_code,
    input  wire logic [9:0] read_index,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      read_data
);

    localparam int PAGE_COUNT  = (SCREEN_HEIGHT + PAGE_BITS - 1) / PAGE_BITS;
    localparam int STORE_BYTES = SCREEN_WIDTH * PAGE_COUNT;
    localparam int AW          = $clog2(STORE_BYTES);
    localparam logic [AW-1:0]     LAST_ADDR = AW'(STORE_BYTES - 1);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(STEPS - 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DRAW,
        ST_READ_ISSUE,
        ST_READ_DATA
    } state_t;

    state_t              state_reg,     state_next;
    logic [AW-1:0]       clr_addr_reg,  clr_addr_next;
    logic [STEP_W-1:0]   step_reg,      step_next;
    glyph_t              glyph_reg,     glyph_next;
    logic [7:0]          pos_x_reg,     pos_x_next;
    logic [6:0]          pos_y_reg,     pos_y_next;
    logic [AW-1:0]       rd_addr_reg,   rd_addr_next;
    logic                rd_ok_reg,     rd_ok_next;
    logic                s1_valid_reg,  s1_valid_next;
    logic [AW-1:0]       s1_addr_reg,   s1_addr_next;
    logic [7:0]          s1_mask_reg,   s1_mask_next;
    logic                out_valid_reg, out_valid_next;
    logic [7:0]          read_data_reg, read_data_next;

    // Frame store RAM
    logic [7:0]    store_mem [STORE_BYTES];
    logic [7:0]    mem_rdata_reg;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic [AW-1:0] mem_raddr;

    // Draw step decode
    logic [2:0]            step_col;
    logic                  step_hi;
    logic [GLYPH_ROWS-1:0] col_bits;
    logic [15:0]           col_shifted;
    logic [7:0]            page_bits;
    logic [8:0]            col_x;
    logic [4:0]            page_num;
    logic [7:0]            row_mask;
    logic [7:0]            draw_mask;
    logic                  draw_hit;
    logic [31:0]           draw_addr_wide;
    logic [AW-1:0]         draw_addr;
    logic [31:0]           rd_index_wide;
    int                    rows_left;

    // Work out the page byte touched by the current draw step
    always_comb
    begin
        step_col    = step_reg[STEP_W-1:1];
        step_hi     = step_reg[0];
        col_bits    = glyph_reg[step_col];
        col_shifted = 16'(col_bits) << pos_y_reg[2:0];
        page_bits   = step_hi ? col_shifted[15:8] : col_shifted[7:0];
        col_x       = 9'(pos_x_reg) + 9'(step_col);
        page_num    = 5'(pos_y_reg[6:3]) + 5'(step_hi);

        // Drop rows at or below the bottom edge
        rows_left = SCREEN_HEIGHT - PAGE_BITS * int'(page_num);
        if (rows_left >= PAGE_BITS)
        begin
            row_mask = 8'hFF;
        end
        else if (rows_left <= 0)
        begin
            row_mask = 8'h00;
        end
        else
        begin
            row_mask = 8'((16'd1 << rows_left[3:0]) - 16'd1);
        end

        draw_mask      = page_bits & row_mask;
        draw_hit       = (draw_mask != 8'h00) && (32'(col_x) < SCREEN_WIDTH);
        draw_addr_wide = 32'(col_x) + 32'(page_num) * SCREEN_WIDTH;
        draw_addr      = draw_addr_wide[AW-1:0];
        rd_index_wide  = 32'(read_index);
    end

    // Next-state logic and memory port control
    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        step_next      = step_reg;
        glyph_next     = glyph_reg;
        pos_x_next     = pos_x_reg;
        pos_y_next     = pos_y_reg;
        rd_addr_next   = rd_addr_reg;
        rd_ok_next     = rd_ok_reg;
        s1_valid_next  = 1'b0;
        s1_addr_next   = draw_addr;
        s1_mask_next   = draw_mask;
        out_valid_next = out_valid_reg && out_stall;
        read_data_next = read_data_reg;

        // Write back the pending OR by default
        mem_we    = s1_valid_reg;
        mem_waddr = s1_addr_reg;
        mem_wdata = mem_rdata_reg | s1_mask_reg;
        mem_raddr = draw_addr;

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_addr_reg;
                mem_wdata = 8'h00;
                if (clr_addr_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (req_type)
                        REQ_DRAW:
                        begin
                            glyph_next = glyph_lookup(char_code);
                            pos_x_next = pos_x;
                            pos_y_next = pos_y;
                            step_next  = '0;
                            state_next = ST_DRAW;
                        end
                        REQ_CLEAR:
                        begin
                            clr_addr_next = '0;
                            state_next    = ST_CLEAR;
                        end
                        REQ_READ:
                        begin
                            rd_addr_next = rd_index_wide[AW-1:0];
                            rd_ok_next   = rd_index_wide < STORE_BYTES;
                            state_next   = ST_READ_ISSUE;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_DRAW:
            begin
                // Issue the read; the write follows in the next cycle
                s1_valid_next = draw_hit;
                if (step_reg == LAST_STEP)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_READ_ISSUE:
            begin
                // Hold until the output register is free by next cycle
                mem_raddr = rd_addr_reg;
                if (!out_valid_reg || !out_stall)
                begin
                    state_next = ST_READ_DATA;
                end
            end
            ST_READ_DATA:
            begin
                out_valid_next = 1'b1;
                read_data_next = rd_ok_reg ? mem_rdata_reg : 8'h00;
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            step_reg      <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            step_reg      <= step_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        glyph_reg     <= glyph_next;
        pos_x_reg     <= pos_x_next;
        pos_y_reg     <= pos_y_next;
        rd_addr_reg   <= rd_addr_next;
        rd_ok_reg     <= rd_ok_next;
        s1_addr_reg   <= s1_addr_next;
        s1_mask_reg   <= s1_mask_next;
        read_data_reg <= read_data_next;
    end

    // Frame store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata_reg <= store_mem[mem_raddr];
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign read_data = read_data_reg;

    // A pending write-back always comes from a draw step
    a_s1_from_draw: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> $past(state_reg) == ST_DRAW)
        else $error("write-back pending without a draw step");

    // The clear sweep never shares the write port with a draw write-back
    a_clear_no_wb: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CLEAR |-> !s1_valid_reg)
        else $error("draw write-back overlaps the clear sweep");

    // Read data only lands in a free output register
    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_READ_DATA |-> !out_valid_reg)
        else $error("read result would overwrite a waiting item");

    // A read result appears in the cycle after its data phase
    a_out_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_READ_DATA)
        else $error("output item without a read");

endmodule

`default_nettype wire

[test/tb_char_glyph_framebuffer_renderer.sv]
// Testbench for char_glyph_framebuffer_renderer: draws, clears and byte reads
// checked against a shadow frame store kept in the bench. Depends on cgfr_pkg
// and the renderer RTL.
`timescale 1ns / 1ps

module tb_char_glyph_framebuffer_renderer;
    import cgfr_pkg::*;

    localparam int SCREEN_W     = 128;
    localparam int SCREEN_H     = 64;
    localparam int FB_BYTES     = SCREEN_W * ((SCREEN_H + PAGE_BITS - 1) / PAGE_BITS);
    localparam int RANDOM_ITEMS = 1900;
    localparam int MAX_REPORTS  = 10;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int TAIL_CYCLES  = 1100;
    localparam int RECENT_DEPTH = 8;

    // Unused request code, ignored by the block
    localparam logic [1:0] REQ_NONE = 2'd3;

    // Font: codes in lookup order, five columns per glyph, leftmost byte first
    localparam logic [0:25][7:0] FONT_CODE = "0123456789AFGHKLMOXYZ:-.% ";
    localparam logic [0:25][39:0] FONT_BITS = {
        40'h3E_51_49_45_3E, 40'h00_42_7F_40_00, 40'h42_61_51_49_46,
        40'h21_41_45_4B_31, 40'h18_14_12_7F_10, 40'h27_45_45_45_39,
        40'h3C_4A_49_49_30, 40'h01_71_09_05_03, 40'h36_49_49_49_36,
        40'h06_49_49_29_1E, 40'h7E_11_11_11_7E, 40'h7F_09_09_09_01,
        40'h3E_41_49_49_7A, 40'h7F_08_08_08_7F, 40'h7F_08_14_22_41,
        40'h7F_40_40_40_40, 40'h7F_02_0C_02_7F, 40'h3E_41_41_41_3E,
        40'h63_14_08_14_63, 40'h07_08_70_08_07, 40'h61_51_49_45_43,
        40'h00_36_36_00_00, 40'h08_08_08_08_08, 40'h00_60_60_00_00,
        40'h62_64_08_13_23, 40'h00_00_00_00_00
    };

    typedef struct packed {
        logic [1:0] req;
        logic [7:0] x;
        logic [6:0] y;
        logic [7:0] code;
        logic [9:0] idx;
        logic       drain_first;
    } fb_request_t;

    typedef struct packed {
        logic [9:0] idx;
        logic [7:0] data;
    } fb_byte_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [1:0] req_type;
    logic [7:0] pos_x;
    logic [6:0] pos_y;
    logic [7:0] char_code;
    logic [9:0] read_index;
    logic       out_valid;
    logic       out_stall;
    logic [7:0] read_data;

    char_glyph_framebuffer_renderer dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .req_type   (req_type),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .char_code  (char_code),
        .read_index (read_index),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .read_data  (read_data)
    );

    logic [7:0]  shadow_fb [FB_BYTES];
    fb_request_t request_fifo[$];
    fb_byte_t    expected_bytes[$];
    fb_request_t cur_req;
    fb_byte_t    want;
    int          queued_count;
    int          accepted_count;
    int          error_count;
    int          cycle_count;
    int          burst_left;
    int          gap_left;
    int          stall_mode;
    int          stall_span;
    logic        next_valid;

    // Clock
    initial clk = 1'b0;
    always #4 clk = ~clk;

    // Look up the five glyph columns of a code; unknown codes are blank
    function automatic logic [39:0] glyph_columns(input logic [7:0] code);
        for (int g = 0; g < 26; g++)
            if (FONT_CODE[g] == code)
                return FONT_BITS[g];
        return '0;
    endfunction

    // OR the set glyph pixels into the shadow store, dropping off-screen ones
    task automatic paint_glyph(input logic [7:0] x, input logic [6:0] y,
                               input logic [7:0] code);
        logic [39:0] cols;
        logic [7:0]  column;
        int          px;
        int          py;
        cols = glyph_columns(code);
        for (int c = 0; c < GLYPH_COLS; c++)
        begin
            column = cols[39 - 8 * c -: 8];
            for (int r = 0; r < GLYPH_ROWS; r++)
            begin
                px = int'(x) + c;
                py = int'(y) + r;
                if (column[r] && px < SCREEN_W && py < SCREEN_H)
                    shadow_fb[px + (py / PAGE_BITS) * SCREEN_W][py % PAGE_BITS] = 1'b1;
            end
        end
    endtask

    // Apply one accepted item to the shadow store; reads queue their byte
    task automatic render_request(input fb_request_t r);
        fb_byte_t b;
        case (r.req)
            REQ_DRAW:
                paint_glyph(r.x, r.y, r.code);
            REQ_CLEAR:
                for (int i = 0; i < FB_BYTES; i++)
                    shadow_fb[i] = 8'h00;
            REQ_READ:
            begin
                b.idx  = r.idx;
                b.data = (int'(r.idx) < FB_BYTES) ? shadow_fb[r.idx] : 8'h00;
                expected_bytes.push_back(b);
            end
            default:
                ;
        endcase
    endtask

    task automatic queue_request(input logic [1:0] req, input logic [7:0] x,
                                 input logic [6:0] y, input logic [7:0] code,
                                 input logic [9:0] idx, input logic drain_first);
        fb_request_t r;
        r.req         = req;
        r.x           = x;
        r.y           = y;
        r.code        = code;
        r.idx         = idx;
        r.drain_first = drain_first;
        request_fifo.push_back(r);
        queued_count++;
    endtask

    task automatic note_error(input string what, input logic [9:0] idx,
                              input logic [7:0] exp_data, input logic [7:0] got_data);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("ERROR %s: index %0d expected 0x%02h actual 0x%02h",
                     what, idx, exp_data, got_data);
    endtask

    // Driver: bursts of items with random gaps, payload held while stalled
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                render_request(cur_req);
                accepted_count++;
            end
            if (!(in_valid && in_stall))
            begin
                next_valid = 1'b0;
                if (gap_left != 0)
                    gap_left--;
                else if (request_fifo.size() != 0 &&
                         !(request_fifo[0].drain_first && expected_bytes.size() != 0))
                begin
                    cur_req    = request_fifo.pop_front();
                    next_valid = 1'b1;
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                    else
                        burst_left--;
                end
                in_valid   <= next_valid;
                req_type   <= cur_req.req;
                pos_x      <= cur_req.x;
                pos_y      <= cur_req.y;
                char_code  <= cur_req.code;
                read_index <= cur_req.idx;
            end
        end
    end

    // Monitor: check each read byte against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_bytes.size() == 0)
                    note_error("unexpected result", '0, '0, read_data);
                else
                begin
                    want = expected_bytes.pop_front();
                    if (read_data !== want.data)
                        note_error("read_data mismatch", want.idx, want.data, read_data);
                end
            end
            // Stall pattern: spans of no stall, coin-flip stall and heavy stall
            if (stall_span == 0)
            begin
                stall_mode = $urandom_range(0, 2);
                stall_span = $urandom_range(20, 200);
            end
            else
                stall_span--;
            case (stall_mode)
                0:       out_stall <= 1'b0;
                1:       out_stall <= 1'($urandom_range(0, 1));
                default: out_stall <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin : stimulus
        int          counted;
        int          pick;
        int          recent_n;
        int          col;
        int          page;
        int          slot;
        logic [1:0]  req;
        logic [7:0]  x;
        logic [6:0]  y;
        logic [7:0]  code;
        logic [9:0]  idx;
        logic        drain;
        logic [7:0]  recent_x [RECENT_DEPTH];
        logic [6:0]  recent_y [RECENT_DEPTH];

        rst_n          = 1'b0;
        in_valid       = 1'b0;
        out_stall      = 1'b0;
        req_type       = REQ_DRAW;
        pos_x          = '0;
        pos_y          = '0;
        char_code      = '0;
        read_index     = '0;
        cur_req        = '0;
        queued_count   = 0;
        accepted_count = 0;
        error_count    = 0;
        cycle_count    = 0;
        burst_left     = 0;
        gap_left       = 0;
        stall_mode     = 0;
        stall_span     = 0;
        recent_n       = 0;
        for (int i = 0; i < FB_BYTES; i++)
            shadow_fb[i] = 8'h00;

        // Directed: empty store after reset, clipping at the right and bottom edges, blanks
        queue_request(REQ_READ,  8'd0,   7'd0,   8'h00, 10'd0,    1'b0);
        queue_request(REQ_READ,  8'd0,   7'd0,   8'h00, 10'd1023, 1'b0);
        queue_request(REQ_DRAW,  8'd0,   7'd0,   8'h38, 10'd0,    1'b0); // '8'
        queue_request(REQ_READ,  8'd0,   7'd0,   8'h00, 10'd1,    1'b0);
        queue_request(REQ_DRAW,  8'd123, 7'd60,  8'h41, 10'd0,    1'b0); // 'A' bottom edge
        queue_request(REQ_DRAW,  8'd125, 7'd57,  8'h4D, 10'd0,    1'b0); // 'M' right edge
        queue_request(REQ_READ,  8'd0,   7'd0,   8'h00, 10'd1023, 1'b0);
        queue_request(REQ_READ,  8'd0,   7'd0,   8'h00, 10'd1019, 1'b0);
        queue_request(REQ_DRAW,  8'd255, 7'd127, 8'h25, 10'd0,    1'b0); // all off screen
        queue_request(REQ_DRAW,  8'd126, 7'd5,   8'h5A, 10'd0,    1'b0); // spans two pages
        queue_request(REQ_READ,  8'd0,   7'd0,   8'h00, 10'd126,  1'b0);
        queue_request(REQ_READ,  8'd0,   7'd0,   8'h00, 10'd254,  1'b0);
        queue_request(REQ_DRAW,  8'd10,  7'd10,  8'h42, 10'd0,    1'b0); // 'B' has no glyph
        queue_request(REQ_DRAW,  8'd20,  7'd20,  8'h20, 10'd0,    1'b0); // space
        queue_request(REQ_READ,  8'd0,   7'd0,   8'h00, 10'd138,  1'b0);
        queue_request(REQ_NONE,  8'd255, 7'd127, 8'hFF, 10'd1023, 1'b0); // ignored code
        queue_request(REQ_DRAW,  8'd40,  7'd30,  8'h3A, 10'd0,    1'b0); // colon
        queue_request(REQ_DRAW,  8'd45,  7'd30,  8'h2D, 10'd0,    1'b0); // dash
        queue_request(REQ_DRAW,  8'd50,  7'd30,  8'h2E, 10'd0,    1'b0); // dot
        queue_request(REQ_READ,  8'd0,   7'd0,   8'h00, 10'd430,  1'b0);
        queue_request(REQ_CLEAR, 8'd0,   7'd0,   8'h00, 10'd0,    1'b1);
        queue_request(REQ_READ,  8'd0,   7'd0,   8'h00, 10'd1023, 1'b0);
        queue_request(REQ_READ,  8'd0,   7'd0,   8'h00, 10'd1,    1'b0);
        queue_request(REQ_DRAW,  8'd0,   7'd0,   8'hFF, 10'd0,    1'b0); // blank high code
        queue_request(REQ_READ,  8'd0,   7'd0,   8'h00, 10'd0,    1'b0);

        // Random: mostly on-screen glyphs, reads aimed at recent drawings
        counted = 0;
        while (counted < RANDOM_ITEMS)
        begin
            pick  = $urandom_range(0, 999);
            x     = 8'($urandom_range(0, 255));
            y     = 7'($urandom_range(0, 127));
            code  = 8'($urandom_range(0, 255));
            idx   = 10'($urandom_range(0, 1023));
            drain = ($urandom_range(0, 99) == 0);
            if (pick < 6)
                req = REQ_CLEAR;
            else if (pick < 26)
                req = REQ_NONE;
            else if (pick < 600)
            begin
                req  = REQ_DRAW;
                pick = $urandom_range(0, 9);
                if (pick < 7)
                begin
                    x = 8'($urandom_range(0, SCREEN_W - 1));
                    y = 7'($urandom_range(0, SCREEN_H - 1));
                end
                else if (pick < 9)
                begin
                    x = 8'($urandom_range(SCREEN_W - 8, SCREEN_W + 7));
                    y = 7'($urandom_range(SCREEN_H - 8, SCREEN_H + 7));
                end
                if ($urandom_range(0, 9) < 8)
                    code = FONT_CODE[$urandom_range(0, 25)];
                recent_x[recent_n % RECENT_DEPTH] = x;
                recent_y[recent_n % RECENT_DEPTH] = y;
                recent_n++;
            end
            else
            begin
                req = REQ_READ;
                if (recent_n != 0 && $urandom_range(0, 9) < 7)
                begin
                    slot = $urandom_range(0, (recent_n < RECENT_DEPTH ? recent_n : RECENT_DEPTH) - 1);
                    col  = int'(recent_x[slot]) + $urandom_range(0, GLYPH_COLS - 1);
                    page = int'(recent_y[slot]) / PAGE_BITS + $urandom_range(0, 1);
                    if (col < SCREEN_W && page < SCREEN_H / PAGE_BITS)
                        idx = 10'(col + page * SCREEN_W);
                end
            end
            queue_request(req, x, y, code, idx, drain);
            if (req != REQ_NONE)
                counted++;
        end

        // Release reset and let the queue drain
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        while (accepted_count < queued_count)
            @(posedge clk);
        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (error_count == 0 && expected_bytes.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
